>>> design/qat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants for the quoted argument tokenizer: result kinds,
// quote codes, special byte values and the per-line flag state.
// ----------------------------------------------------------------------------
package qat_pkg;

	// result kinds
	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_TOKEN_END = 2'd1;
	localparam logic [1:0] KIND_LINE_END  = 2'd2;
	localparam logic [1:0] KIND_TOK_LINE  = 2'd3;

	// open quote codes
	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
	localparam logic [1:0] QUOTE_SINGLE = 2'd2;

	// special bytes
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_CARET   = 8'h5E;
	localparam logic [7:0] CH_DEL     = 8'h7F;
	localparam logic [7:0] CTRL_MASK  = 8'h1F;

	// per-line flag state
	typedef struct packed {
		logic       in_token;
		logic [1:0] quote_kind;
		logic       caret_pending;
		logic       overflow_seen;
	} flags_t;

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [5:0] token_index;
		logic [6:0] token_count;
		logic       overflow;
	} result_t;

endpackage
`default_nettype wire

>>> design/qat_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qat_step
// Next-state and result logic for one byte: caret escapes, line end,
// blank splitting, quoting and token counting with saturation.
// ----------------------------------------------------------------------------
module qat_step #(
	parameter int MAX_TOKENS = 64,
	parameter int CNT_W      = 7
) (
	input  wire logic                 fancy,
	input  wire logic [7:0]           in_byte,
	input  wire qat_pkg::flags_t      flags,
	input  wire logic [CNT_W-1:0]     cnt,
	output qat_pkg::flags_t           flags_n,
	output logic [CNT_W-1:0]          cnt_n,
	output logic                      res_valid,
	output qat_pkg::result_t          res
);
	import qat_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TOKENS);
	localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

	logic [1:0]       qk;
	logic             cp;
	logic             blank;
	logic             at_max;
	logic [1:0]       q_code;
	logic [CNT_W-1:0] ecnt;
	logic             eovf;
	logic             idx_zero;
	logic [CNT_W-1:0] cur_idx;

	// byte classes
	assign blank  = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
	assign at_max = (cnt >= MAX_CNT);
	assign q_code = (in_byte == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
	// plain mode sees no open quote and no pending caret
	assign qk     = fancy ? flags.quote_kind : QUOTE_NONE;
	assign cp     = fancy & flags.caret_pending;

	// decision for one byte
	always_comb begin
		flags_n               = flags;
		flags_n.quote_kind    = qk;
		flags_n.caret_pending = cp;
		cnt_n                 = cnt;
		res_valid             = 1'b0;
		res.kind              = KIND_BYTE;
		res.data_byte         = 8'h00;
		ecnt                  = cnt;
		eovf                  = flags.overflow_seen;
		idx_zero              = 1'b0;

		if (cp && (in_byte != CH_NUL)) begin
			// caret escape consumes this byte
			flags_n.caret_pending = 1'b0;
			res_valid             = 1'b1;
			if (in_byte == CH_CARET) begin
				res.data_byte = CH_CARET;
			end else if (in_byte == CH_QMARK) begin
				res.data_byte = CH_DEL;
			end else begin
				res.data_byte = in_byte & CTRL_MASK;
			end
		end else if ((in_byte == CH_NL) || (in_byte == CH_NUL)) begin
			// line end reports the final count, then state returns to reset
			res_valid     = 1'b1;
			res.kind      = flags.in_token ? KIND_TOK_LINE : KIND_LINE_END;
			idx_zero      = ~flags.in_token;
			flags_n       = '0;
			cnt_n         = '0;
		end else if (blank) begin
			if (flags.in_token && (qk != QUOTE_NONE)) begin
				res_valid     = 1'b1;
				res.data_byte = in_byte;
			end else if (flags.in_token) begin
				flags_n.in_token = 1'b0;
				res_valid        = 1'b1;
				res.kind         = KIND_TOKEN_END;
			end
		end else begin
			// any other byte opens a token if none is open
			if (!flags.in_token) begin
				flags_n.in_token = 1'b1;
				if (at_max) begin
					flags_n.overflow_seen = 1'b1;
				end else begin
					cnt_n = cnt + ONE;
				end
			end
			ecnt = cnt_n;
			eovf = flags_n.overflow_seen;
			if (fancy && (in_byte == CH_CARET)) begin
				flags_n.caret_pending = 1'b1;
			end else if (fancy && ((in_byte == CH_DQUOTE) || (in_byte == CH_SQUOTE))
			             && ((qk == q_code) || (qk == QUOTE_NONE))) begin
				// open or close a quote; the other kind is literal
				flags_n.quote_kind = (qk == q_code) ? QUOTE_NONE : q_code;
			end else begin
				res_valid     = 1'b1;
				res.data_byte = in_byte;
			end
		end

		cur_idx         = (ecnt == '0) ? '0 : (ecnt - ONE);
		res.token_index = idx_zero ? 6'd0 : 6'(cur_idx);
		res.token_count = 7'(ecnt);
		res.overflow    = eovf;
	end

endmodule
`default_nettype wire

>>> design/quoted_argument_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a byte stream into blank/tab separated tokens, with optional
// quoting and caret escapes, reporting token bytes, token ends and line ends.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and each byte yields at most one result. A byte
// sits in an input register, is decided there by a single combinational step
// against the per-line state, and its result lands in an output register. The
// stream runs at one byte per cycle while out_stall stays low. A stall on a held
// result keeps the byte in the input register and raises in_stall in the same
// cycle. fancy_mode is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer #(
	parameter int MAX_TOKENS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      data_byte,
	output logic [5:0]      token_index,
	output logic [6:0]      token_count,
	output logic            overflow
);
	import qat_pkg::*;

	localparam int CNT_W = $clog2(MAX_TOKENS + 1);

	logic             fancy_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	flags_t           flags_q;
	flags_t           flags_n;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_n;
	logic             res_valid;
	result_t          res;
	logic             out_valid_q;
	result_t          res_q;
	logic             out_free;
	logic             adv;
	logic             in_xfer;

	// handshake control
	assign out_free = ~out_valid_q | ~out_stall;
	assign adv      = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;
	assign in_xfer  = in_valid & ~in_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fancy_q <= 1'b0;
		end else if (cfg_we) begin
			fancy_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= in_byte;
		end
	end

	// per-byte decision
	qat_step #(
		.MAX_TOKENS (MAX_TOKENS),
		.CNT_W      (CNT_W)
	) u_step (
		.fancy     (fancy_q),
		.in_byte   (byte_s1),
		.flags     (flags_q),
		.cnt       (cnt_q),
		.flags_n   (flags_n),
		.cnt_n     (cnt_n),
		.res_valid (res_valid),
		.res       (res)
	);

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			cnt_q   <= '0;
		end else if (adv) begin
			flags_q <= flags_n;
			cnt_q   <= cnt_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = res_q.kind;
	assign data_byte   = res_q.data_byte;
	assign token_index = res_q.token_index;
	assign token_count = res_q.token_count;
	assign overflow    = res_q.overflow;

endmodule
`default_nettype wire
